// ----- hdl/lwit_pkg.sv -----
`timescale 1ns / 1ps
package lwit_pkg;

  localparam int unsigned TokenChars   = 16;
  localparam int unsigned IdentEntries = 128;
  localparam int unsigned TokW         = TokenChars * 8;
  localparam int unsigned LenW         = $clog2(TokenChars + 1);
  localparam int unsigned SlotW        = $clog2(IdentEntries);
  localparam int unsigned CntW         = $clog2(IdentEntries + 1);
  localparam int unsigned NumKeywords  = 7;
  localparam int unsigned QDepth       = 2;

  typedef enum logic [2:0] {
    KIND_KEYWORD = 3'd0,
    KIND_NEW     = 3'd1,
    KIND_KNOWN   = 3'd2,
    KIND_PUNCT   = 3'd3,
    KIND_SYMBOL  = 3'd4,
    KIND_FULL    = 3'd5
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
  } lex_in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] code;
    logic       truncated;
    logic       last;
  } lex_out_t;

  // Front-to-back work descriptor.
  typedef struct packed {
    logic            has_tok;
    logic [TokW-1:0] tok;
    logic            trunc;
    logic            has_sym;
    logic [7:0]      sym;
  } lex_job_t;

  function automatic logic is_token_byte(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == ".";
  endfunction

  function automatic logic is_punct_byte(logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  // Keyword text, byte 0 in the low byte, zero padded.
  function automatic logic [63:0] kw_word(int unsigned k);
    logic [63:0] w;
    w = '0;
    unique case (k)
      0: w = 64'h0000_0000_0074_6e69;
      1: w = 64'h0000_0074_616f_6c66;
      2: w = 64'h0000_0000_0000_6669;
      3: w = 64'h0000_0000_6573_6c65;
      4: w = 64'h0000_0065_6c69_6877;
      5: w = 64'h0000_0000_0072_6f66;
      default: w = 64'h0000_6e72_7574_6572;
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/lwit_ram.sv -----
`timescale 1ns / 1ps
module lwit_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- hdl/lwit_front.sv -----
`timescale 1ns / 1ps
module lwit_front import lwit_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lex_in_t  in_data_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output lex_job_t job_o
);
  logic [TokW-1:0] tok_q, tok_d;
  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic            tokb, ws, acc;

  assign tokb = !in_data_i.is_end && is_token_byte(in_data_i.ch);
  assign ws   = in_data_i.ch == " " || in_data_i.ch == 8'h0A || in_data_i.ch == 8'h09;

  always_comb begin
    job_o.has_tok = len_q != '0;
    job_o.tok     = tok_q;
    job_o.trunc   = ovf_q;
    job_o.has_sym = !in_data_i.is_end && !ws;
    job_o.sym     = in_data_i.ch;
  end

  // Token bytes are absorbed here; a beat that ends a token, or a non-whitespace byte, becomes a job.
  assign job_valid_o = in_valid_i && !tokb && (job_o.has_tok || job_o.has_sym);
  assign in_ready_o  = tokb || !(job_o.has_tok || job_o.has_sym) || job_ready_i;
  assign acc         = in_valid_i && in_ready_o;

  always_comb begin
    tok_d = tok_q;
    len_d = len_q;
    ovf_d = ovf_q;
    if (acc) begin
      if (tokb) begin
        if (len_q < LenW'(TokenChars)) begin
          tok_d[len_q[LenW-2:0]*8 +: 8] = in_data_i.ch;
          len_d = len_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end else begin
        tok_d = '0;
        len_d = '0;
        ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      tok_q <= tok_d;
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end
endmodule

// ----- hdl/lwit_fifo.sv -----
`timescale 1ns / 1ps
module lwit_fifo import lwit_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  lex_job_t wdata_i,
  input  logic     pop_i,
  output logic     empty_o,
  output lex_job_t rdata_o
);
  lex_job_t slot_q [QDepth];
  logic     wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'(QDepth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) slot_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= !wp_q;
      if (pop_i && !empty_o) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end
endmodule

// ----- hdl/lwit_back.sv -----
`timescale 1ns / 1ps
module lwit_back import lwit_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_empty_i,
  input  lex_job_t job_i,
  output logic     job_pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lex_out_t out_data_o
);
  typedef enum logic [2:0] {
    BK_IDLE, BK_KW, BK_SCAN, BK_TOKOUT, BK_SYMOUT
  } bk_state_e;

  bk_state_e       st_q, st_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            rdv_q, rdv_d;
  logic [SlotW-1:0] rslot_q, rslot_d;
  logic [2:0]      kind_q, kind_d;
  logic [7:0]      code_q, code_d;
  logic            we;
  logic [TokW-1:0] rdata;
  logic            kw_hit;
  logic [2:0]      kw_idx;
  lex_out_t        res_q, res_d;
  logic            ov_q, ov_d;

  lwit_ram #(.Width(TokW), .Depth(IdentEntries)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cnt_q[SlotW-1:0]),
    .wdata_i(job_i.tok),
    .raddr_i(idx_q[SlotW-1:0]),
    .rdata_o(rdata)
  );

  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int k = NumKeywords - 1; k >= 0; k--) begin
      if (job_i.tok == TokW'(kw_word(k))) begin
        kw_hit = 1'b1;
        kw_idx = 3'(k);
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = res_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; idx_d = idx_q; rdv_d = 1'b0; rslot_d = rslot_q;
    kind_d = kind_q; code_d = code_q; res_d = res_q; ov_d = ov_q;
    we = 1'b0; job_pop_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      BK_IDLE: if (!job_empty_i) begin
        st_d = job_i.has_tok ? BK_KW : BK_SYMOUT;
      end
      BK_KW: begin
        idx_d = '0;
        if (kw_hit) begin
          kind_d = KIND_KEYWORD; code_d = 8'(kw_idx); st_d = BK_TOKOUT;
        end else st_d = BK_SCAN;
      end
      BK_SCAN: begin
        // One read issued per cycle; compare data for the previous address.
        if (rdv_q && rdata == job_i.tok) begin
          kind_d = KIND_KNOWN; code_d = 8'(rslot_q); st_d = BK_TOKOUT;
        end else if (idx_q < cnt_q) begin
          rdv_d = 1'b1; rslot_d = idx_q[SlotW-1:0]; idx_d = idx_q + 1'b1;
        end else begin
          if (cnt_q < CntW'(IdentEntries)) begin
            we = 1'b1; kind_d = KIND_NEW; code_d = 8'(cnt_q); cnt_d = cnt_q + 1'b1;
          end else begin
            kind_d = KIND_FULL; code_d = '0;
          end
          st_d = BK_TOKOUT;
        end
      end
      BK_TOKOUT: if (!ov_d) begin
        res_d = '{kind: kind_q, code: code_q, truncated: job_i.trunc,
                  last: !job_i.has_sym};
        ov_d = 1'b1;
        if (job_i.has_sym) st_d = BK_SYMOUT;
        else begin
          st_d = BK_IDLE; job_pop_o = 1'b1;
        end
      end
      BK_SYMOUT: if (!ov_d) begin
        res_d = '{kind: is_punct_byte(job_i.sym) ? KIND_PUNCT : KIND_SYMBOL,
                  code: job_i.sym, truncated: 1'b0, last: 1'b1};
        ov_d = 1'b1; st_d = BK_IDLE; job_pop_o = 1'b1;
      end
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_IDLE; cnt_q <= '0; idx_q <= '0; rdv_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; idx_q <= idx_d; rdv_q <= rdv_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rslot_q <= rslot_d; kind_q <= kind_d; code_q <= code_d; res_q <= res_d;
  end
endmodule

// ----- hdl/lexer_with_identifier_table.sv -----
`timescale 1ns / 1ps
// Channel  Signals                         Beat
// in       in_valid_i/in_ready_o/in_data_i  one source byte or end marker
// out      out_valid_o/out_ready_i/out_data_o  one classified result
//
// The front end absorbs token bytes without back-pressure. A token-ending
// beat is queued; the back end checks the token against the keywords and,
// if none match, scans the identifiers (one table RAM read per cycle).
// Reset clears the token buffer, queue and identifier count; the table RAM
// is not cleared. A stalled output holds the back end; the two-entry queue
// lets the front end keep collecting bytes meanwhile.
module lexer_with_identifier_table import lwit_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lex_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lex_out_t out_data_o
);
  logic     job_valid, job_full, job_empty, job_pop;
  lex_job_t job_w, job_r;

  // Front end: gather tokens, hand off completed work.
  lwit_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .job_valid_o(job_valid), .job_ready_i(!job_full), .job_o(job_w)
  );

  // Decouple front and back.
  lwit_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(job_valid), .full_o(job_full), .wdata_i(job_w),
    .pop_i(job_pop), .empty_o(job_empty), .rdata_o(job_r)
  );

  // Back end: classify, scan the table, emit results.
  lwit_back u_back (
    .clk_i, .rst_ni, .job_empty_i(job_empty), .job_i(job_r), .job_pop_o(job_pop),
    .out_valid_o, .out_ready_i, .out_data_o
  );

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped while stalled");
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.kind <= KIND_FULL)
    else $error("bad result kind");
  a_sym_untrunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_PUNCT || out_data_o.kind == KIND_SYMBOL)
    |-> out_data_o.last && !out_data_o.truncated)
    else $error("symbol result malformed");
endmodule
